// ----- sv/nsh_pkg.sv -----
// Shared constants, widths and types of the nearest sphere hit core.
`timescale 1ns / 1ps

package nsh_pkg;

    localparam int NUM_SPHERES = 8;
    localparam int SLOT_W      = 3;
    localparam int FRAC_BITS   = 12;
    localparam int CRD_W       = 32;
    localparam int RAD_W       = 31;
    localparam int TOL_W       = 12;
    localparam int DIST_W      = 31;

    localparam int DMAG_W  = 32;                 // |d|
    localparam int OCMAG_W = 33;                 // |o - c|
    localparam int A_W     = 64;                 // d.d
    localparam int H_W     = 67;                 // oc.d, signed
    localparam int OCC_W   = 66;                 // oc.oc
    localparam int C_W     = 67;                 // oc.oc - r*r, signed
    localparam int HMAG_W  = 66;
    localparam int CMAG_W  = 66;
    localparam int SQ_W    = 132;                // discriminant
    localparam int S_W     = SQ_W / 2;           // its root
    localparam int ROOT_W  = 68;                 // -h -/+ s, signed
    localparam int NUM_W   = ROOT_W - 1 + FRAC_BITS;
    localparam int ACC_W   = 134;
    localparam int OPB_W   = 67;
    localparam int CNT_W   = 7;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(12);
    localparam logic [63:0]      FAR_LIMIT = 64'd100000000000;
    localparam logic [NUM_W-1:0] FAR_Q     = NUM_W'(FAR_LIMIT) << FRAC_BITS;

    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        AOP_MUL  = 2'd0,
        AOP_SQRT = 2'd1,
        AOP_DIV  = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic             start;
        arith_op_t        op;
        logic [CNT_W-1:0] count;
    } arith_req_t;

endpackage

// ----- sv/nsh_arith.sv -----
// Shared iterative unit: shift-add multiply, digit-by-digit square root, restoring divide.
`timescale 1ns / 1ps

module nsh_arith (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  nsh_pkg::arith_req_t       req,
    input  logic [nsh_pkg::ACC_W-1:0] opa,
    input  logic [nsh_pkg::OPB_W-1:0] opb,
    output logic                      done,
    output logic [nsh_pkg::ACC_W-1:0] result
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [nsh_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    nsh_pkg::arith_op_t        op_reg, op_next;
    logic [nsh_pkg::ACC_W-1:0] x_reg, x_next;
    logic [nsh_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [nsh_pkg::OPB_W-1:0] y_reg, y_next;

    logic [nsh_pkg::ACC_W-1:0] rem_sh;
    logic [nsh_pkg::ACC_W-1:0] sub_op;
    logic                      ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        y_next    = y_reg;
        rem_sh    = '0;
        sub_op    = '0;
        ge        = 1'b0;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            op_next   = req.op;
            x_next    = opa;
            acc_next  = '0;
            y_next    = (req.op == nsh_pkg::AOP_SQRT) ? '0 : opb;
        end else if (busy_reg) begin
            case (op_reg)
                nsh_pkg::AOP_MUL: begin
                    acc_next = y_reg[0] ? acc_reg + x_reg : acc_reg;
                    x_next   = {x_reg[nsh_pkg::ACC_W-2:0], 1'b0};
                    y_next   = {1'b0, y_reg[nsh_pkg::OPB_W-1:1]};
                end
                nsh_pkg::AOP_SQRT: begin
                    rem_sh   = {acc_reg[nsh_pkg::ACC_W-3:0],
                                x_reg[nsh_pkg::SQ_W-1 -: 2]};
                    sub_op   = {{(nsh_pkg::ACC_W-nsh_pkg::OPB_W-2){1'b0}}, y_reg, 2'b01};
                    ge       = (rem_sh >= sub_op);
                    acc_next = ge ? rem_sh - sub_op : rem_sh;
                    x_next   = {x_reg[nsh_pkg::ACC_W-3:0], 2'b00};
                    y_next   = {y_reg[nsh_pkg::OPB_W-2:0], ge};
                end
                nsh_pkg::AOP_DIV: begin
                    rem_sh   = {acc_reg[nsh_pkg::ACC_W-2:0], x_reg[nsh_pkg::NUM_W-1]};
                    sub_op   = {{(nsh_pkg::ACC_W-nsh_pkg::OPB_W){1'b0}}, y_reg};
                    ge       = (rem_sh >= sub_op);
                    acc_next = ge ? rem_sh - sub_op : rem_sh;
                    x_next   = {x_reg[nsh_pkg::ACC_W-2:0], ge};
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == nsh_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        op_reg  <= op_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign done = done_reg;

    always_comb begin
        case (op_reg)
            nsh_pkg::AOP_MUL:  result = acc_reg;
            nsh_pkg::AOP_SQRT: result = {{(nsh_pkg::ACC_W-nsh_pkg::OPB_W){1'b0}}, y_reg};
            nsh_pkg::AOP_DIV:  result = {{(nsh_pkg::ACC_W-nsh_pkg::NUM_W){1'b0}},
                                         x_reg[nsh_pkg::NUM_W-1:0]};
            default:           result = acc_reg;
        endcase
    end

endmodule

// ----- sv/nearest_sphere_hit_core.sv -----
// Top level: sphere table, query sequencer and result register.
`timescale 1ns / 1ps

// Closest-hit ray/sphere test over an eight-entry sphere table in Q19.12.
// A load transfer writes one entry. A query runs every multiply, the square
// root and the divides through one shared bit-serial unit, so its run time
// grows with each valid sphere (less when a sphere misses or its nearer root
// is taken). The input is not ready while a query is in progress. One result
// transfer follows each query, none a load; a finished result waits in the
// output register while the next item is taken. The tolerance register may
// be written at any time the core is idle and is always ready.

module nearest_sphere_hit_core (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [nsh_pkg::SLOT_W-1:0]   s_sphere_slot,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_center_x,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_center_y,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_center_z,
    input  logic [nsh_pkg::RAD_W-1:0]    s_radius,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_origin_x,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_origin_y,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_origin_z,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_dir_x,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_dir_y,
    input  logic signed [nsh_pkg::CRD_W-1:0] s_dir_z,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [nsh_pkg::SLOT_W-1:0]   m_hit_index,
    output logic [nsh_pkg::DIST_W-1:0]   m_hit_distance,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [nsh_pkg::TOL_W-1:0]    cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_OC    = 7'b0000010,
        ST_ISSUE = 7'b0000100,
        ST_WAIT  = 7'b0001000,
        ST_ROOT  = 7'b0010000,
        ST_NEXT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        P_A    = 3'd0,
        P_H    = 3'd1,
        P_OCC  = 3'd2,
        P_RR   = 3'd3,
        P_HH   = 3'd4,
        P_AC   = 3'd5,
        P_SQRT = 3'd6,
        P_DIV  = 3'd7
    } phase_t;

    // sphere table
    logic signed [nsh_pkg::CRD_W-1:0] cx_reg [nsh_pkg::NUM_SPHERES];
    logic signed [nsh_pkg::CRD_W-1:0] cy_reg [nsh_pkg::NUM_SPHERES];
    logic signed [nsh_pkg::CRD_W-1:0] cz_reg [nsh_pkg::NUM_SPHERES];
    logic [nsh_pkg::RAD_W-1:0]        rad_reg [nsh_pkg::NUM_SPHERES];
    logic [nsh_pkg::NUM_SPHERES-1:0]  valid_reg;
    logic [nsh_pkg::TOL_W-1:0]        tol_reg;

    // query operands
    logic signed [nsh_pkg::CRD_W-1:0] o_reg [3];
    logic [nsh_pkg::DMAG_W-1:0]       dmag_reg [3];
    logic [2:0]                       dneg_reg;
    logic [nsh_pkg::OCMAG_W-1:0]      ocmag_reg [3];
    logic [2:0]                       ocneg_reg;

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [1:0]                i_reg, i_next;
    logic [nsh_pkg::SLOT_W-1:0] k_reg, k_next;
    logic [nsh_pkg::A_W-1:0]   a_reg, a_next;
    logic signed [nsh_pkg::H_W-1:0] h_reg, h_next;
    logic [nsh_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic                      cneg_reg, cneg_next;
    logic [nsh_pkg::CMAG_W-1:0] cmag_reg, cmag_next;
    logic [nsh_pkg::SQ_W-1:0]  hh_reg, hh_next;
    logic [nsh_pkg::SQ_W-1:0]  disc_reg, disc_next;
    logic [nsh_pkg::S_W-1:0]   s_reg, s_next;
    logic                      found_reg, found_next;
    logic [nsh_pkg::NUM_W-1:0] best_reg, best_next;
    logic [nsh_pkg::SLOT_W-1:0] bestk_reg, bestk_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_hit_reg, m_hit_next;
    logic [nsh_pkg::SLOT_W-1:0] m_idx_reg, m_idx_next;
    logic [nsh_pkg::DIST_W-1:0] m_dist_reg, m_dist_next;

    logic signed [nsh_pkg::CRD_W-1:0] dir_in [3];
    logic [nsh_pkg::DMAG_W-1:0]       dmag_in [3];
    logic signed [nsh_pkg::CRD_W-1:0] ctr_k [3];
    logic signed [nsh_pkg::OCMAG_W-1:0] oc_c [3];
    logic [nsh_pkg::OCMAG_W-1:0]      ocmag_c [3];

    logic                   s_xfer;
    logic                   load_oc;
    logic [nsh_pkg::HMAG_W-1:0] hmag;
    logic signed [nsh_pkg::ROOT_W-1:0] nh, root;
    logic [nsh_pkg::NUM_W-1:0] num;
    logic signed [nsh_pkg::C_W-1:0]  c_w;
    logic [nsh_pkg::SQ_W-1:0]  ac_w;
    logic [nsh_pkg::H_W-1:0]   prod_h;
    logic [nsh_pkg::NUM_W-1:0] q_w;
    logic                      q_pass;

    nsh_pkg::arith_req_t       ar_req;
    logic [nsh_pkg::ACC_W-1:0] ar_opa;
    logic [nsh_pkg::OPB_W-1:0] ar_opb;
    logic                      ar_done;
    logic [nsh_pkg::ACC_W-1:0] ar_result;

    nsh_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ar_req),
        .opa     (ar_opa),
        .opb     (ar_opb),
        .done    (ar_done),
        .result  (ar_result)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign dir_in[0] = s_dir_x;
    assign dir_in[1] = s_dir_y;
    assign dir_in[2] = s_dir_z;
    assign ctr_k[0]  = cx_reg[k_reg];
    assign ctr_k[1]  = cy_reg[k_reg];
    assign ctr_k[2]  = cz_reg[k_reg];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dmag_in[j] = dir_in[j][nsh_pkg::CRD_W-1] ? nsh_pkg::DMAG_W'(-dir_in[j])
                                                     : nsh_pkg::DMAG_W'(dir_in[j]);
            oc_c[j]    = nsh_pkg::OCMAG_W'(o_reg[j]) - nsh_pkg::OCMAG_W'(ctr_k[j]);
            ocmag_c[j] = oc_c[j][nsh_pkg::OCMAG_W-1] ? nsh_pkg::OCMAG_W'(-oc_c[j])
                                                     : nsh_pkg::OCMAG_W'(oc_c[j]);
        end
    end

    assign hmag = h_reg[nsh_pkg::H_W-1] ? nsh_pkg::HMAG_W'(-h_reg)
                                        : nsh_pkg::HMAG_W'(h_reg);
    assign nh   = -nsh_pkg::ROOT_W'(h_reg);
    assign root = i_reg[0] ? nh + $signed({2'b00, s_reg}) : nh - $signed({2'b00, s_reg});
    assign num  = {root[nsh_pkg::ROOT_W-2:0], {nsh_pkg::FRAC_BITS{1'b0}}};

    assign c_w    = $signed({1'b0, occ_reg}) -
                    $signed({1'b0, ar_result[nsh_pkg::C_W-2:0]});
    assign ac_w   = ar_result[nsh_pkg::SQ_W-1:0];
    assign prod_h = ar_result[nsh_pkg::H_W-1:0];
    assign q_w    = ar_result[nsh_pkg::NUM_W-1:0];
    assign q_pass = (q_w > nsh_pkg::NUM_W'(tol_reg)) && (q_w < nsh_pkg::FAR_Q);

    // operand selection for the shared unit
    always_comb begin
        ar_req.start = (state_reg == ST_ISSUE);
        ar_req.op    = nsh_pkg::AOP_MUL;
        ar_req.count = nsh_pkg::CNT_W'(nsh_pkg::DMAG_W);
        ar_opa       = '0;
        ar_opb       = '0;
        case (phase_reg)
            P_A: begin
                ar_opa = nsh_pkg::ACC_W'(dmag_reg[i_reg]);
                ar_opb = nsh_pkg::OPB_W'(dmag_reg[i_reg]);
            end
            P_H: begin
                ar_opa = nsh_pkg::ACC_W'(ocmag_reg[i_reg]);
                ar_opb = nsh_pkg::OPB_W'(dmag_reg[i_reg]);
            end
            P_OCC: begin
                ar_opa       = nsh_pkg::ACC_W'(ocmag_reg[i_reg]);
                ar_opb       = nsh_pkg::OPB_W'(ocmag_reg[i_reg]);
                ar_req.count = nsh_pkg::CNT_W'(nsh_pkg::OCMAG_W);
            end
            P_RR: begin
                ar_opa       = nsh_pkg::ACC_W'(rad_reg[k_reg]);
                ar_opb       = nsh_pkg::OPB_W'(rad_reg[k_reg]);
                ar_req.count = nsh_pkg::CNT_W'(nsh_pkg::RAD_W);
            end
            P_HH: begin
                ar_opa       = nsh_pkg::ACC_W'(hmag);
                ar_opb       = nsh_pkg::OPB_W'(hmag);
                ar_req.count = nsh_pkg::CNT_W'(nsh_pkg::HMAG_W);
            end
            P_AC: begin
                ar_opa       = nsh_pkg::ACC_W'(cmag_reg);
                ar_opb       = nsh_pkg::OPB_W'(a_reg);
                ar_req.count = nsh_pkg::CNT_W'(nsh_pkg::A_W);
            end
            P_SQRT: begin
                ar_req.op    = nsh_pkg::AOP_SQRT;
                ar_opa       = nsh_pkg::ACC_W'(disc_reg);
                ar_req.count = nsh_pkg::CNT_W'(nsh_pkg::S_W);
            end
            P_DIV: begin
                ar_req.op    = nsh_pkg::AOP_DIV;
                ar_opa       = nsh_pkg::ACC_W'(num);
                ar_opb       = nsh_pkg::OPB_W'(a_reg);
                ar_req.count = nsh_pkg::CNT_W'(nsh_pkg::NUM_W);
            end
            default: begin
                ar_opa = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        a_next       = a_reg;
        h_next       = h_reg;
        occ_next     = occ_reg;
        cneg_next    = cneg_reg;
        cmag_next    = cmag_reg;
        hh_next      = hh_reg;
        disc_next    = disc_reg;
        s_next       = s_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        bestk_next   = bestk_reg;
        load_oc      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        m_idx_next   = m_idx_reg;
        m_dist_next  = m_dist_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_opcode == nsh_pkg::OPC_QUERY) begin
                    found_next = 1'b0;
                    a_next     = '0;
                    i_next     = '0;
                    phase_next = P_A;
                    state_next = ST_ISSUE;
                end
            end
            ST_OC: begin
                if (!valid_reg[k_reg]) begin
                    state_next = ST_NEXT;
                end else begin
                    load_oc    = 1'b1;
                    h_next     = '0;
                    occ_next   = '0;
                    i_next     = '0;
                    phase_next = P_H;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (ar_done) begin
                    state_next = ST_ISSUE;
                    case (phase_reg)
                        P_A: begin
                            a_next = a_reg + ar_result[nsh_pkg::A_W-1:0];
                            i_next = i_reg + 1'b1;
                            if (i_reg == 2'd2) begin
                                k_next     = '0;
                                state_next = (a_next == '0) ? ST_DONE : ST_OC;
                            end
                        end
                        P_H: begin
                            h_next = (ocneg_reg[i_reg] ^ dneg_reg[i_reg])
                                   ? h_reg - $signed(prod_h) : h_reg + $signed(prod_h);
                            i_next = i_reg + 1'b1;
                            if (i_reg == 2'd2) begin
                                i_next     = '0;
                                phase_next = P_OCC;
                            end
                        end
                        P_OCC: begin
                            occ_next = occ_reg + ar_result[nsh_pkg::OCC_W-1:0];
                            i_next   = i_reg + 1'b1;
                            if (i_reg == 2'd2) begin
                                phase_next = P_RR;
                            end
                        end
                        P_RR: begin
                            cneg_next  = c_w[nsh_pkg::C_W-1];
                            cmag_next  = c_w[nsh_pkg::C_W-1] ? nsh_pkg::CMAG_W'(-c_w)
                                                             : nsh_pkg::CMAG_W'(c_w);
                            phase_next = P_HH;
                        end
                        P_HH: begin
                            hh_next    = ar_result[nsh_pkg::SQ_W-1:0];
                            phase_next = P_AC;
                        end
                        P_AC: begin
                            phase_next = P_SQRT;
                            if (cneg_reg) begin
                                disc_next = hh_reg + ac_w;
                            end else if (hh_reg < ac_w) begin
                                state_next = ST_NEXT;
                            end else begin
                                disc_next = hh_reg - ac_w;
                            end
                        end
                        P_SQRT: begin
                            s_next     = ar_result[nsh_pkg::S_W-1:0];
                            i_next     = '0;
                            state_next = ST_ROOT;
                        end
                        P_DIV: begin
                            if (q_pass) begin
                                if (!found_reg || q_w < best_reg) begin
                                    found_next = 1'b1;
                                    best_next  = q_w;
                                    bestk_next = k_reg;
                                end
                                state_next = ST_NEXT;
                            end else if (i_reg == 2'd0) begin
                                i_next     = 2'd1;
                                state_next = ST_ROOT;
                            end else begin
                                state_next = ST_NEXT;
                            end
                        end
                        default: begin
                            state_next = ST_NEXT;
                        end
                    endcase
                end
            end
            ST_ROOT: begin
                if (root[nsh_pkg::ROOT_W-1] || root == '0) begin
                    if (i_reg == 2'd0) begin
                        i_next = 2'd1;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end else begin
                    phase_next = P_DIV;
                    state_next = ST_ISSUE;
                end
            end
            ST_NEXT: begin
                if (k_reg == nsh_pkg::SLOT_W'(nsh_pkg::NUM_SPHERES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_OC;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = found_reg;
                    m_idx_next   = found_reg ? bestk_reg : '0;
                    if (!found_reg) begin
                        m_dist_next = '0;
                    end else if (|best_reg[nsh_pkg::NUM_W-1:nsh_pkg::DIST_W]) begin
                        m_dist_next = '1;
                    end else begin
                        m_dist_next = best_reg[nsh_pkg::DIST_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            tol_reg     <= nsh_pkg::TOL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                tol_reg <= cfg_data;
            end
            if (s_xfer && s_opcode == nsh_pkg::OPC_LOAD) begin
                valid_reg[s_sphere_slot] <= 1'b1;
            end
        end
        phase_reg  <= phase_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        h_reg      <= h_next;
        occ_reg    <= occ_next;
        cneg_reg   <= cneg_next;
        cmag_reg   <= cmag_next;
        hh_reg     <= hh_next;
        disc_reg   <= disc_next;
        s_reg      <= s_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        bestk_reg  <= bestk_next;
        m_hit_reg  <= m_hit_next;
        m_idx_reg  <= m_idx_next;
        m_dist_reg <= m_dist_next;

        if (s_xfer && s_opcode == nsh_pkg::OPC_LOAD) begin
            cx_reg[s_sphere_slot]  <= s_center_x;
            cy_reg[s_sphere_slot]  <= s_center_y;
            cz_reg[s_sphere_slot]  <= s_center_z;
            rad_reg[s_sphere_slot] <= s_radius;
        end
        if (s_xfer && s_opcode == nsh_pkg::OPC_QUERY) begin
            o_reg[0] <= s_origin_x;
            o_reg[1] <= s_origin_y;
            o_reg[2] <= s_origin_z;
            for (int j = 0; j < 3; j++) begin
                dmag_reg[j] <= dmag_in[j];
                dneg_reg[j] <= dir_in[j][nsh_pkg::CRD_W-1];
            end
        end
        if (load_oc) begin
            for (int j = 0; j < 3; j++) begin
                ocmag_reg[j] <= ocmag_c[j];
                ocneg_reg[j] <= oc_c[j][nsh_pkg::OCMAG_W-1];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_hit_index    = m_idx_reg;
    assign m_hit_distance = m_dist_reg;

endmodule
